// ===== design/mmp_pkg.sv =====
// mmp_pkg: shared constants, codes and control types of the modular matrix power unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmp_pkg;

    // default sizes
    localparam int MAX_DIM_DEF    = 8;
    localparam int VALUE_BITS_DEF = 31;

    // fixed field widths
    localparam int POS_BITS     = 3;
    localparam int EXP_BITS     = 31;
    localparam int DIM_BITS     = 4;
    localparam int CFG_IDX_BITS = 1;

    // register reset values
    localparam int MOD_RESET = 1000000007;
    localparam int DIM_RESET = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIM     = 1'd1;

    // regions of the matrix memory
    typedef enum logic [1:0] {
        RGN_BASE,
        RGN_ACC,
        RGN_SQR,
        RGN_TMP
    } t_region;

    // source of memory write data
    typedef enum logic [2:0] {
        WS_ZERO,
        WS_ONE,
        WS_RED,
        WS_RDATA,
        WS_ACC
    } t_wsel;

    // controller states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_GO,
        ST_LD_WAIT,
        ST_INIT,
        ST_CP_RD,
        ST_CP_WR,
        ST_STEP,
        ST_MM_RDA,
        ST_MM_RDB,
        ST_MM_GO,
        ST_MM_ST,
        ST_MM_WAIT,
        ST_MM_WR,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic                in_ready;
        logic                ram_we;
        t_wsel               wsel;
        logic                mm_start;
        logic                mm_reduce;
        logic                opa_cap;
        logic                opb_cap;
        logic                acc_clr;
        logic                acc_add;
        logic                exp_shift;
        logic                out_load;
        logic [POS_BITS-1:0] out_row;
        logic [POS_BITS-1:0] out_col;
        logic                out_last;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic                in_valid;
        logic                in_last;
        logic                pos_ok;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                mm_done;
        logic                exp_zero;
        logic                exp_bit0;
        logic                out_free;
        logic [DIM_BITS-1:0] dim;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/mmp_in_if.sv =====
// mmp_in_if: input channel carrying matrix entries and the exponent
// depends on mmp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mmp_in_if
    import mmp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [POS_BITS-1:0]   row_index;
    logic [POS_BITS-1:0]   col_index;
    logic [VALUE_BITS-1:0] entry_value;
    logic [EXP_BITS-1:0]   exponent;
    logic                  load_last;

    modport source (output valid, row_index, col_index, entry_value, exponent, load_last,
                    input ready);
    modport sink (input valid, row_index, col_index, entry_value, exponent, load_last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/mmp_out_if.sv =====
// mmp_out_if: output channel carrying result entries
// depends on mmp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mmp_out_if
    import mmp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [POS_BITS-1:0]   out_row;
    logic [POS_BITS-1:0]   out_col;
    logic [VALUE_BITS-1:0] out_value;
    logic                  out_last;

    modport source (output valid, out_row, out_col, out_value, out_last, input ready);
    modport sink (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

`default_nettype wire

// ===== design/mmp_ram.sv =====
// mmp_ram: generic single write, single read memory with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mmp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== design/mmp_modmul.sv =====
// mmp_modmul: bit-serial modular multiplier, x is reduced then multiplied by y,
// unless only reduction is asked; depends on mmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmp_modmul
    import mmp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_reduce_only,
    input  wire logic [VALUE_BITS-1:0] i_x,
    input  wire logic [VALUE_BITS-1:0] i_y,
    input  wire logic [VALUE_BITS-1:0] i_m,
    output      logic                  o_done,
    output      logic [VALUE_BITS-1:0] o_res
);
    localparam int CW = $clog2(VALUE_BITS);
    localparam int RW = VALUE_BITS + 2;

    logic                  r_busy, r_mul, r_done, r_red_only;
    logic [CW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_x, r_y, r_r, r_xr;
    logic [RW-1:0]         m_ext, red_t, mul_t, mul_u;
    logic [RW-1:0]         red_nxt, mul_nxt;

    // one step of each phase
    always_comb begin
        m_ext   = {2'b00, i_m};
        red_t   = {1'b0, r_r, r_x[VALUE_BITS-1]};
        red_nxt = (red_t >= m_ext) ? red_t - m_ext : red_t;
        mul_t   = {1'b0, r_r, 1'b0} + (r_y[VALUE_BITS-1] ? {2'b00, r_xr} : '0);
        mul_u   = (mul_t >= m_ext) ? mul_t - m_ext : mul_t;
        mul_nxt = (mul_u >= m_ext) ? mul_u - m_ext : mul_u;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0 && (r_mul || r_red_only)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // data path of the unit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul      <= 1'b0;
            r_red_only <= i_reduce_only;
            r_cnt      <= CW'(VALUE_BITS - 1);
            r_x        <= i_x;
            r_y        <= i_y;
            r_r        <= '0;
        end else if (r_busy && !r_mul) begin
            r_x <= r_x << 1;
            if (r_cnt == '0 && !r_red_only) begin
                r_mul <= 1'b1;
                r_xr  <= red_nxt[VALUE_BITS-1:0];
                r_r   <= '0;
                r_cnt <= CW'(VALUE_BITS - 1);
            end else begin
                r_r   <= red_nxt[VALUE_BITS-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
        end else if (r_busy) begin
            r_y   <= r_y << 1;
            r_r   <= mul_nxt[VALUE_BITS-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_r;
endmodule

`default_nettype wire

// ===== design/mmp_datapath.sv =====
// mmp_datapath: configuration, input capture, matrix memory, modular unit, output register
// depends on mmp_pkg, mmp_in_if, mmp_out_if, mmp_ram, mmp_modmul
`timescale 1ns / 1ps
`default_nettype none

module mmp_datapath
    import mmp_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]              i_cfg_idx,
    input  wire logic [VALUE_BITS-1:0]                i_cfg_data,
    mmp_in_if.sink                                    i_in,
    mmp_out_if.source                                 o_out,
    input  wire t_cmd                                 i_cmd,
    input  wire logic [$clog2(4*MAX_DIM*MAX_DIM)-1:0] i_raddr,
    input  wire logic [$clog2(4*MAX_DIM*MAX_DIM)-1:0] i_waddr,
    output      t_sts                                 o_sts
);
    localparam int DEPTH = 4 * MAX_DIM * MAX_DIM;

    logic [VALUE_BITS-1:0] r_mod, m_eff, rdata, wdata, mm_res, mm_x, mm_y;
    logic [DIM_BITS-1:0]   r_dim, dim_eff;
    logic [POS_BITS-1:0]   r_row, r_col;
    logic [VALUE_BITS-1:0] r_val, r_opa, r_opb, r_acc;
    logic [EXP_BITS-1:0]   r_exp;
    logic                  r_last, r_out_valid, mm_done;
    logic [VALUE_BITS:0]   sum, sum_red;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= VALUE_BITS'(MOD_RESET);
            r_dim <= DIM_BITS'(DIM_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODULUS: r_mod <= i_cfg_data;
                REG_DIM:     r_dim <= i_cfg_data[DIM_BITS-1:0];
                default:     r_mod <= r_mod;
            endcase
        end
    end

    // zero modulus acts as one, dimension clamped to 1..MAX_DIM
    always_comb begin
        m_eff   = (r_mod == '0) ? VALUE_BITS'(1) : r_mod;
        dim_eff = r_dim;
        if (r_dim == '0) begin
            dim_eff = DIM_BITS'(1);
        end else if (r_dim > DIM_BITS'(MAX_DIM)) begin
            dim_eff = DIM_BITS'(MAX_DIM);
        end
    end

    // input capture and exponent
    assign i_in.ready = i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_cmd.in_ready) begin
            r_row  <= i_in.row_index;
            r_col  <= i_in.col_index;
            r_val  <= i_in.entry_value;
            r_exp  <= i_in.exponent;
            r_last <= i_in.load_last;
        end else if (i_cmd.exp_shift) begin
            r_exp <= r_exp >> 1;
        end
    end

    // operands and running sum of products
    assign sum     = {1'b0, r_acc} + {1'b0, mm_res};
    assign sum_red = (sum >= {1'b0, m_eff}) ? sum - {1'b0, m_eff} : sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.opa_cap) begin
            r_opa <= rdata;
        end
        if (i_cmd.opb_cap) begin
            r_opb <= rdata;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= sum_red[VALUE_BITS-1:0];
        end
    end

    // modular unit
    assign mm_x = i_cmd.mm_reduce ? r_val : r_opa;
    assign mm_y = i_cmd.mm_reduce ? VALUE_BITS'(1) : r_opb;

    mmp_modmul #(
        .VALUE_BITS (VALUE_BITS)
    ) u_modmul (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_cmd.mm_start),
        .i_reduce_only (i_cmd.mm_reduce),
        .i_x           (mm_x),
        .i_y           (mm_y),
        .i_m           (m_eff),
        .o_done        (mm_done),
        .o_res         (mm_res)
    );

    // write data select
    always_comb begin
        unique case (i_cmd.wsel)
            WS_ZERO:  wdata = '0;
            WS_ONE:   wdata = (m_eff == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
            WS_RED:   wdata = mm_res;
            WS_RDATA: wdata = rdata;
            WS_ACC:   wdata = r_acc;
            default:  wdata = '0;
        endcase
    end

    // matrix memory: base, accumulator, square and scratch regions
    mmp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (i_waddr),
        .i_wdata (wdata),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out.out_row   <= i_cmd.out_row;
            o_out.out_col   <= i_cmd.out_col;
            o_out.out_value <= rdata;
            o_out.out_last  <= i_cmd.out_last;
        end
    end

    assign o_out.valid = r_out_valid;

    // status
    always_comb begin
        o_sts.in_valid = i_in.valid;
        o_sts.in_last  = r_last;
        o_sts.pos_ok   = ({1'b0, r_row} < DIM_BITS'(MAX_DIM))
                         && ({1'b0, r_col} < DIM_BITS'(MAX_DIM));
        o_sts.row      = r_row;
        o_sts.col      = r_col;
        o_sts.mm_done  = mm_done;
        o_sts.exp_zero = (r_exp == '0);
        o_sts.exp_bit0 = r_exp[0];
        o_sts.out_free = !r_out_valid || o_out.ready;
        o_sts.dim      = dim_eff;
    end
endmodule

`default_nettype wire

// ===== design/mmp_ctrl.sv =====
// mmp_ctrl: sequencer for loading, square-and-multiply, matrix products and result output
// depends on mmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmp_ctrl
    import mmp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire t_sts                                 i_sts,
    output      t_cmd                                 o_cmd,
    output      logic [$clog2(4*MAX_DIM*MAX_DIM)-1:0] o_raddr,
    output      logic [$clog2(4*MAX_DIM*MAX_DIM)-1:0] o_waddr
);
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(4 * CELLS);

    t_state              r_state, n_state;
    logic [DIM_BITS-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    t_region             r_a, n_a, r_b, n_b, r_d, n_d, r_src, n_src, r_dst, n_dst;
    logic                r_phase, n_phase;
    logic [DIM_BITS-1:0] last_idx;
    logic                last_j, last_cell, clr_last_j, clr_last;

    function automatic logic [AW-1:0] f_addr(t_region rg, logic [DIM_BITS-1:0] row,
                                             logic [DIM_BITS-1:0] col);
        return AW'(int'(rg) * CELLS + int'(row) * MAX_DIM + int'(col));
    endfunction

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_phase <= 1'b0;
            r_a     <= RGN_ACC;
            r_b     <= RGN_SQR;
            r_d     <= RGN_ACC;
            r_src   <= RGN_BASE;
            r_dst   <= RGN_SQR;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_phase <= n_phase;
            r_a     <= n_a;
            r_b     <= n_b;
            r_d     <= n_d;
            r_src   <= n_src;
            r_dst   <= n_dst;
        end
    end

    // next state and commands
    always_comb begin
        last_idx   = i_sts.dim - 1'b1;
        last_j     = (r_j == last_idx);
        last_cell  = last_j && (r_i == last_idx);
        clr_last_j = (r_j == DIM_BITS'(MAX_DIM - 1));
        clr_last   = clr_last_j && (r_i == DIM_BITS'(MAX_DIM - 1));

        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_phase = r_phase;
        n_a     = r_a;
        n_b     = r_b;
        n_d     = r_d;
        n_src   = r_src;
        n_dst   = r_dst;
        o_cmd   = '0;
        o_cmd.wsel = WS_ZERO;
        o_raddr = f_addr(r_src, r_i, r_j);
        o_waddr = f_addr(r_dst, r_i, r_j);

        unique case (r_state)
            // clearing pass over the base region after reset
            ST_CLEAR: begin
                o_cmd.ram_we = 1'b1;
                o_waddr      = f_addr(RGN_BASE, r_i, r_j);
                n_j          = clr_last_j ? '0 : r_j + 1'b1;
                if (clr_last_j) begin
                    n_i = r_i + 1'b1;
                end
                if (clr_last) begin
                    n_i     = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = ST_LD_GO;
                end
            end
            // reduce the entry modulo the modulus
            ST_LD_GO: begin
                o_cmd.mm_start  = 1'b1;
                o_cmd.mm_reduce = 1'b1;
                n_state         = ST_LD_WAIT;
            end
            ST_LD_WAIT: begin
                o_cmd.mm_reduce = 1'b1;
                o_waddr = f_addr(RGN_BASE, DIM_BITS'(i_sts.row), DIM_BITS'(i_sts.col));
                if (i_sts.mm_done) begin
                    o_cmd.ram_we = i_sts.pos_ok;
                    o_cmd.wsel   = WS_RED;
                    n_i          = '0;
                    n_j          = '0;
                    n_state      = i_sts.in_last ? ST_INIT : ST_IDLE;
                end
            end
            // accumulator starts as the identity
            ST_INIT: begin
                o_cmd.ram_we = 1'b1;
                o_cmd.wsel   = (r_i == r_j) ? WS_ONE : WS_ZERO;
                o_waddr      = f_addr(RGN_ACC, r_i, r_j);
                n_j          = last_j ? '0 : r_j + 1'b1;
                if (last_j) begin
                    n_i = r_i + 1'b1;
                end
                if (last_cell) begin
                    n_i     = '0;
                    n_src   = RGN_BASE;
                    n_dst   = RGN_SQR;
                    n_phase = 1'b0;
                    n_state = ST_CP_RD;
                end
            end
            // region copy, a read state then a write state per cell
            ST_CP_RD: begin
                n_state = ST_CP_WR;
            end
            ST_CP_WR: begin
                o_cmd.ram_we = 1'b1;
                o_cmd.wsel   = WS_RDATA;
                n_j          = last_j ? '0 : r_j + 1'b1;
                n_state      = ST_CP_RD;
                if (last_j) begin
                    n_i = r_i + 1'b1;
                end
                if (last_cell) begin
                    n_i     = '0;
                    n_state = ST_STEP;
                end
            end
            // one square-and-multiply decision
            ST_STEP: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                o_cmd.acc_clr = 1'b1;
                n_state = ST_MM_RDA;
                if (r_phase) begin
                    n_a = RGN_SQR;
                    n_b = RGN_SQR;
                    n_d = RGN_SQR;
                    o_cmd.exp_shift = 1'b1;
                    n_phase = 1'b0;
                end else if (i_sts.exp_zero) begin
                    n_state = ST_OUT_RD;
                end else if (i_sts.exp_bit0) begin
                    n_a = RGN_ACC;
                    n_b = RGN_SQR;
                    n_d = RGN_ACC;
                    n_phase = 1'b1;
                end else begin
                    n_a = RGN_SQR;
                    n_b = RGN_SQR;
                    n_d = RGN_SQR;
                    o_cmd.exp_shift = 1'b1;
                end
            end
            // matrix product into the scratch region
            ST_MM_RDA: begin
                o_raddr = f_addr(r_a, r_i, r_k);
                n_state = ST_MM_RDB;
            end
            ST_MM_RDB: begin
                o_raddr       = f_addr(r_b, r_k, r_j);
                o_cmd.opa_cap = 1'b1;
                n_state       = ST_MM_GO;
            end
            ST_MM_GO: begin
                o_raddr       = f_addr(r_b, r_k, r_j);
                o_cmd.opb_cap = 1'b1;
                n_state       = ST_MM_ST;
            end
            ST_MM_ST: begin
                o_cmd.mm_start = 1'b1;
                n_state        = ST_MM_WAIT;
            end
            ST_MM_WAIT: begin
                if (i_sts.mm_done) begin
                    o_cmd.acc_add = 1'b1;
                    if (r_k == last_idx) begin
                        n_state = ST_MM_WR;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_MM_RDA;
                    end
                end
            end
            ST_MM_WR: begin
                o_cmd.ram_we  = 1'b1;
                o_cmd.wsel    = WS_ACC;
                o_waddr       = f_addr(RGN_TMP, r_i, r_j);
                o_cmd.acc_clr = 1'b1;
                n_k           = '0;
                n_j           = last_j ? '0 : r_j + 1'b1;
                n_state       = ST_MM_RDA;
                if (last_j) begin
                    n_i = r_i + 1'b1;
                end
                if (last_cell) begin
                    n_i     = '0;
                    n_src   = RGN_TMP;
                    n_dst   = r_d;
                    n_state = ST_CP_RD;
                end
            end
            // result items in row-major order
            ST_OUT_RD: begin
                o_raddr = f_addr(RGN_ACC, r_i, r_j);
                n_state = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                o_raddr = f_addr(RGN_ACC, r_i, r_j);
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_row  = r_i[POS_BITS-1:0];
                    o_cmd.out_col  = r_j[POS_BITS-1:0];
                    o_cmd.out_last = last_cell;
                    n_j            = last_j ? '0 : r_j + 1'b1;
                    n_state        = ST_OUT_RD;
                    if (last_j) begin
                        n_i = r_i + 1'b1;
                    end
                    if (last_cell) begin
                        n_i     = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

// ===== design/modular_matrix_power_unit.sv =====
// Modular matrix power unit: loads a matrix entry per item, raises it to a power modulo m.
// Load item: the bit-serial modular unit reduces the entry before another is taken.
// Run on the last item: a setup pass builds the identity and copies the base, then one
// product per set exponent bit plus one squaring per bit; results go out row-major.
// Reset: synchronous; a clearing pass zeroes all MAX_DIM*MAX_DIM base entries
// while no item is accepted. Depends on mmp_pkg, interfaces, mmp_ctrl and mmp_datapath.
`timescale 1ns / 1ps
`default_nettype none

module modular_matrix_power_unit
    import mmp_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [VALUE_BITS-1:0]   i_cfg_data,
    mmp_in_if.sink                       i_in,
    mmp_out_if.source                    o_out
);
    localparam int AW = $clog2(4 * MAX_DIM * MAX_DIM);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] raddr, waddr;

    // sequencer
    mmp_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_raddr (raddr),
        .o_waddr (waddr)
    );

    // storage and arithmetic
    mmp_datapath #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .i_raddr    (raddr),
        .i_waddr    (waddr),
        .o_sts      (sts)
    );
endmodule

`default_nettype wire

// ===== test/modular_matrix_power_checker.sv =====
// modular_matrix_power_checker: watches the item channels and configuration writes,
// predicts every result matrix and compares it. Depends on mmp_pkg and the channel interfaces.
`timescale 1ns / 1ps

module modular_matrix_power_checker
    import mmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    mmp_in_if           in_ch,
    mmp_out_if          out_ch,
    output int          o_fail_count,
    output int          o_pending
);

    typedef bit [30:0] t_cells [64];

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [30:0] value;
        logic        last;
    } t_entry;

    // predictor copy of the block state and registers
    t_cells          base_cells;
    longint unsigned modulus_reg;
    bit [3:0]        dim_reg;
    t_entry          result_queue[$];

    // product of two n-by-n corners modulo m
    function automatic t_cells mat_product(input t_cells a, input t_cells b, input int n,
                                           input longint unsigned m);
        t_cells          prod;
        longint unsigned sum;
        longint unsigned x;
        longint unsigned y;
        for (int c = 0; c < 64; c++) prod[c] = '0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                sum = 0;
                for (int k = 0; k < n; k++) begin
                    x = longint'(a[i*8+k]) % m;
                    y = longint'(b[k*8+j]) % m;
                    sum = (sum + (x * y) % m) % m;
                end
                prod[i*8+j] = sum[30:0];
            end
        end
        return prod;
    endfunction

    // raise the loaded matrix to a power and queue every result entry
    task automatic predict_power(input bit [30:0] power);
        t_cells          acc;
        t_cells          sqr;
        longint unsigned m;
        int              n;
        bit [30:0]       left;
        t_entry          e;
        m = (modulus_reg == 0) ? 1 : modulus_reg;
        n = (dim_reg == 0) ? 1 : ((dim_reg > 8) ? 8 : int'(dim_reg));
        for (int c = 0; c < 64; c++) acc[c] = '0;
        for (int i = 0; i < n; i++) acc[i*8+i] = 31'(1 % m);
        sqr = base_cells;
        left = power;
        while (left != 0) begin
            if (left[0]) acc = mat_product(acc, sqr, n, m);
            sqr = mat_product(sqr, sqr, n, m);
            left = left >> 1;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                e.row = i[2:0];
                e.col = j[2:0];
                e.value = acc[i*8+j];
                e.last = (i == n-1) && (j == n-1);
                result_queue.push_back(e);
            end
        end
    endtask

    // watch configuration, input items and result items
    always @(posedge i_clk) begin
        t_entry want;
        longint unsigned m;
        if (!i_rst_n) begin
            modulus_reg = MOD_RESET;
            dim_reg = DIM_RESET;
            for (int c = 0; c < 64; c++) base_cells[c] = '0;
            result_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MODULUS) modulus_reg = i_cfg_data;
                else if (i_cfg_idx == REG_DIM) dim_reg = i_cfg_data[3:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                m = (modulus_reg == 0) ? 1 : modulus_reg;
                base_cells[in_ch.row_index*8 + in_ch.col_index] =
                    31'(longint'(in_ch.entry_value) % m);
                if (in_ch.load_last) predict_power(in_ch.exponent);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (result_queue.size() == 0) begin
                    $error("unexpected result item row %0d col %0d value %0d",
                           out_ch.out_row, out_ch.out_col, out_ch.out_value);
                    o_fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (out_ch.out_row !== want.row) begin
                        $error("out_row expected %0d actual %0d", want.row, out_ch.out_row);
                        o_fail_count++;
                    end
                    if (out_ch.out_col !== want.col) begin
                        $error("out_col expected %0d actual %0d", want.col, out_ch.out_col);
                        o_fail_count++;
                    end
                    if (out_ch.out_value !== want.value) begin
                        $error("out_value expected %0d actual %0d",
                               want.value, out_ch.out_value);
                        o_fail_count++;
                    end
                    if (out_ch.out_last !== want.last) begin
                        $error("out_last expected %0d actual %0d",
                               want.last, out_ch.out_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = result_queue.size();
    end

endmodule

// ===== test/modular_matrix_power_unit_test.sv =====
// modular_matrix_power_unit_test: drives matrix loads, exponent runs and register writes
// into the unit with random idling; checking is done by modular_matrix_power_checker.
`timescale 1ns / 1ps

module modular_matrix_power_unit_test;
    import mmp_pkg::*;

    localparam int STALL_LIMIT = 400000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [30:0]             cfg_data;
    int                      fail_count;
    int                      pending;
    bit                      idling_on;
    int                      items_sent;
    int                      stall_cycles;
    int                      out_gap;

    mmp_in_if  in_ch ();
    mmp_out_if out_ch ();

    modular_matrix_power_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    modular_matrix_power_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result receiver with random stall bursts
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_ch.ready = 1'b0;
            out_gap--;
        end else begin
            out_ch.ready = 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 6);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("modular_matrix_power_unit_test NOT OK");
            $finish;
        end
    end

    // one matrix entry, optionally the last one with the exponent
    task automatic send_entry(input bit [2:0] row, input bit [2:0] col, input bit [30:0] value,
                              input bit [30:0] power, input bit last);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.row_index = row;
        in_ch.col_index = col;
        in_ch.entry_value = value;
        in_ch.exponent = power;
        in_ch.load_last = last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // let every result drain before touching a register
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input bit [30:0] data);
        wait_drained();
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic bit [30:0] rand_value();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 15));
            1: return 31'h7FFFFFFF - 31'($urandom_range(0, 3));
            default: return 31'($urandom());
        endcase
    endfunction

    // stimulus
    initial begin
        int          dim_set;
        int          n;
        int          wmax;
        int          width;
        bit [30:0]   power;
        bit [2:0]    r;
        bit [2:0]    c;
        int          count;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_MODULUS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.entry_value = '0;
        in_ch.exponent = '0;
        in_ch.load_last = 1'b0;
        idling_on = 1'b1;
        items_sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset registers: exponent zero gives the identity
        send_entry(0, 0, 31'h7FFFFFFF, 0, 0);
        send_entry(0, 1, 0, 0, 0);
        send_entry(1, 0, 12345, 0, 0);
        send_entry(1, 1, 5, 0, 1);
        // same base with entry (1,1) replaced, widest exponent
        send_entry(1, 1, 31'h7FFFFFFF, 31'h7FFFFFFF, 1);
        // modulus zero acts as one, dimension zero acts as one, entry outside the corner
        write_reg(REG_MODULUS, 0);
        write_reg(REG_DIM, 0);
        send_entry(7, 7, 99, 3, 1);
        write_reg(REG_MODULUS, 1);
        send_entry(3, 5, 31'h7FFFFFFF, 0, 1);
        // largest modulus on a single entry
        write_reg(REG_MODULUS, 31'h7FFFFFFF);
        write_reg(REG_DIM, 1);
        send_entry(0, 0, 31'h7FFFFFFF, 5, 1);
        send_entry(0, 0, 31'h7FFFFFFE, 31'h55555555, 1);
        // smallest real modulus, three by three
        write_reg(REG_MODULUS, 2);
        write_reg(REG_DIM, 3);
        for (int i = 0; i < 8; i++) send_entry(3'(i / 3), 3'(i % 3), 31'(i * 7 + 1), 0, 0);
        send_entry(2, 2, 3, 6, 1);
        // modulus changed after loading
        write_reg(REG_MODULUS, 13);
        send_entry(2, 2, 31'h7FFFFFFF, 3, 1);
        // dimension above the maximum saturates, then the maximum itself
        write_reg(REG_MODULUS, 1000000007);
        write_reg(REG_DIM, 15);
        send_entry(7, 0, rand_value(), 0, 0);
        send_entry(7, 7, rand_value(), 2, 1);
        write_reg(REG_DIM, 8);
        send_entry(4, 6, rand_value(), 1, 1);

        // random phases
        while (items_sent < 460) begin
            if (items_sent >= 400) idling_on = 1'b0;
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(REG_MODULUS, 31'($urandom_range(2, 16)));
                    1: write_reg(REG_MODULUS, 31'($urandom_range(2, 65535)));
                    default: write_reg(REG_MODULUS, 31'($urandom_range(2, 32'h7FFFFFFF)));
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 8))
                    0: dim_set = 0;
                    1, 2: dim_set = 1;
                    3, 4, 5: dim_set = 2;
                    6, 7: dim_set = 3;
                    default: dim_set = 4;
                endcase
                write_reg(REG_DIM, 4'(dim_set));
                n = (dim_set == 0) ? 1 : dim_set;
            end else if (items_sent < 40) begin
                write_reg(REG_DIM, 2);
                n = 2;
            end
            wmax = (n <= 2) ? 31 : ((n == 3) ? 8 : 3);
            if ($urandom_range(0, 3) == 0) width = $urandom_range(0, wmax);
            else width = $urandom_range(0, (wmax < 6) ? wmax : 6);
            power = 31'($urandom()) & 31'((64'd1 << width) - 1);
            if ($urandom_range(0, 3) != 0) begin
                // full matrix in row-major order
                for (int i = 0; i < n * n; i++)
                    send_entry(3'(i / n), 3'(i % n), rand_value(), power, i == n * n - 1);
            end else begin
                // scattered entries, some outside the corner in use
                count = $urandom_range(0, n * n + 2);
                for (int i = 0; i < count; i++) begin
                    r = 3'($urandom_range(0, 7));
                    c = 3'($urandom_range(0, 7));
                    send_entry(r, c, rand_value(), 31'($urandom()), 0);
                end
                send_entry(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_value(),
                           power, 1);
            end
        end

        // drain and verdict
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) $display("modular_matrix_power_unit_test OK");
        else $display("modular_matrix_power_unit_test NOT OK");
        $finish;
    end

endmodule
